// ===== design/urlcp_pkg.sv =====
package urlcp_pkg;

  // default limit on url length in bytes
  localparam int unsigned MAX_LEN_DEF = 1024;

  localparam int unsigned LEN_OUT_W = 11;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned ACC_W     = 17;

  localparam logic [ACC_W-1:0] PORT_SAT = 17'd65536;
  localparam logic [ACC_W-1:0] PORT_MAX = 17'd65535;
  localparam logic [2:0]       DIG_MAX  = 3'd5;
  localparam logic [2:0]       DIG_SAT  = 3'd6;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;

  typedef enum logic [7:0] {
    PH_PROTO = 8'b0000_0001,
    PH_COLON = 8'b0000_0010,
    PH_SLASH = 8'b0000_0100,
    PH_HOST  = 8'b0000_1000,
    PH_PORT  = 8'b0001_0000,
    PH_PATH  = 8'b0010_0000,
    PH_QUERY = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } step_t;

  typedef struct packed {
    logic                 ok;
    logic [LEN_OUT_W-1:0] proto_len;
    logic [LEN_OUT_W-1:0] host_len;
    logic                 port_present;
    logic [PORT_W-1:0]    port_value;
    logic [LEN_OUT_W-1:0] path_len;
    logic [LEN_OUT_W-1:0] query_len;
  } url_result_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic port_ok(input logic [2:0] digits, input logic [ACC_W-1:0] acc);
    return (digits >= 3'd1) && (digits <= DIG_MAX) && (acc >= 17'd1) && (acc <= PORT_MAX);
  endfunction

endpackage

// ===== design/urlcp_core.sv =====
module urlcp_core #(
  parameter int unsigned MAX_LEN = urlcp_pkg::MAX_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  urlcp_pkg::step_t       step,
  output urlcp_pkg::url_result_t result
);
  import urlcp_pkg::*;

  // the byte counter reaches MAX_LEN + 1 at most
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 2);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [LEN_W-1:0]   cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0]   proto_len_r, proto_len_nxt;
  logic [LEN_W-1:0]   host_len_r, host_len_nxt;
  logic [LEN_W-1:0]   path_len_r, path_len_nxt;
  logic [LEN_W-1:0]   query_len_r, query_len_nxt;
  logic [ACC_W-1:0]   port_acc_r, port_acc_nxt;
  logic [2:0]         port_dig_r, port_dig_nxt;
  logic [1:0]         esc_left_r, esc_left_nxt;
  logic               failed_r, failed_nxt;
  logic               port_taken_r, port_taken_nxt;

  always_comb begin
    logic [7:0]       c;
    logic [19:0]      acc_mul;
    logic             fail_f;
    logic             taken_f;
    logic [LEN_W-1:0] host_f;
    logic [LEN_W-1:0] path_f;
    logic [LEN_W-1:0] query_f;

    c              = step.ch;
    acc_mul        = ({3'b000, port_acc_r} << 3) + ({3'b000, port_acc_r} << 1)
                     + {16'd0, c[3:0]};
    phase_nxt      = phase_r;
    byte_cnt_nxt   = byte_cnt_r;
    cur_len_nxt    = cur_len_r;
    proto_len_nxt  = proto_len_r;
    host_len_nxt   = host_len_r;
    path_len_nxt   = path_len_r;
    query_len_nxt  = query_len_r;
    port_acc_nxt   = port_acc_r;
    port_dig_nxt   = port_dig_r;
    esc_left_nxt   = esc_left_r;
    failed_nxt     = failed_r;
    port_taken_nxt = port_taken_r;

    // overlong input check
    if (byte_cnt_r <= LEN_LIMIT) byte_cnt_nxt = byte_cnt_r + LEN_ONE;
    if (byte_cnt_nxt > LEN_LIMIT) failed_nxt = 1'b1;

    case (phase_r)
      PH_PROTO: begin
        if (is_alnum(c) || c == CH_UNDER) begin
          cur_len_nxt = cur_len_r + LEN_ONE;
        end else if (c == CH_COLON && cur_len_r != '0) begin
          proto_len_nxt = cur_len_r;
          phase_nxt     = PH_COLON;
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_DONE;
        end
      end
      PH_COLON: begin
        if (c == CH_SLASH) begin
          phase_nxt = PH_SLASH;
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_DONE;
        end
      end
      PH_SLASH: begin
        if (c == CH_SLASH && !step.last) begin
          phase_nxt   = PH_HOST;
          cur_len_nxt = '0;
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_DONE;
        end
      end
      PH_HOST: begin
        if (is_alnum(c) || c == CH_UNDER || c == CH_DASH || c == CH_DOT) begin
          cur_len_nxt = cur_len_r + LEN_ONE;
        end else if (c == CH_COLON) begin
          host_len_nxt = cur_len_r;
          phase_nxt    = PH_PORT;
        end else if (c == CH_SLASH) begin
          host_len_nxt = cur_len_r;
          cur_len_nxt  = LEN_ONE;
          phase_nxt    = PH_PATH;
        end else if (c == CH_QMARK && cur_len_r == '0) begin
          cur_len_nxt = LEN_ONE;
          phase_nxt   = PH_QUERY;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_PORT: begin
        if (is_digit(c)) begin
          if (port_dig_r < DIG_SAT) port_dig_nxt = port_dig_r + 3'd1;
          if (acc_mul > {3'b000, PORT_SAT}) port_acc_nxt = PORT_SAT;
          else port_acc_nxt = acc_mul[ACC_W-1:0];
        end else if (c == CH_SLASH) begin
          if (port_ok(port_dig_r, port_acc_r)) begin
            port_taken_nxt = 1'b1;
            cur_len_nxt    = LEN_ONE;
            phase_nxt      = PH_PATH;
          end else begin
            failed_nxt = 1'b1;
            phase_nxt  = PH_DONE;
          end
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_PATH, PH_QUERY: begin
        if (esc_left_r != 2'd0) begin
          if (is_hex(c)) begin
            cur_len_nxt  = cur_len_r + LEN_ONE;
            esc_left_nxt = esc_left_r - 2'd1;
          end else begin
            phase_nxt = PH_DONE;
          end
        end else if (is_alnum(c) || c == CH_UNDER || c == CH_DASH || c == CH_DOT ||
                     (phase_r == PH_PATH && (c == CH_SLASH || c == CH_COLON)) ||
                     (phase_r == PH_QUERY && (c == CH_EQUAL || c == CH_AMP))) begin
          cur_len_nxt = cur_len_r + LEN_ONE;
        end else if (c == CH_PERCENT) begin
          cur_len_nxt  = cur_len_r + LEN_ONE;
          esc_left_nxt = 2'd2;
        end else if (c == CH_HASH) begin
          if (phase_r == PH_PATH) path_len_nxt = cur_len_r;
          else query_len_nxt = cur_len_r;
          phase_nxt = PH_DONE;
        end else if (c == CH_QMARK && phase_r == PH_PATH) begin
          path_len_nxt = cur_len_r;
          cur_len_nxt  = LEN_ONE;
          phase_nxt    = PH_QUERY;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // end of url: close the open component
    fail_f  = failed_nxt;
    taken_f = port_taken_nxt;
    host_f  = host_len_nxt;
    path_f  = path_len_nxt;
    query_f = query_len_nxt;
    case (phase_nxt)
      PH_PROTO, PH_COLON, PH_SLASH: fail_f = 1'b1;
      PH_HOST:  host_f = cur_len_nxt;
      PH_PORT: begin
        if (port_ok(port_dig_nxt, port_acc_nxt)) taken_f = 1'b1;
        else fail_f = 1'b1;
      end
      PH_PATH:  if (esc_left_nxt == 2'd0) path_f = cur_len_nxt;
      PH_QUERY: if (esc_left_nxt == 2'd0) query_f = cur_len_nxt;
      default: begin
      end
    endcase

    result = '0;
    if (!fail_f) begin
      result.ok           = 1'b1;
      result.proto_len    = LEN_OUT_W'(proto_len_nxt);
      result.host_len     = LEN_OUT_W'(host_f);
      result.port_present = taken_f;
      result.port_value   = taken_f ? port_acc_nxt[PORT_W-1:0] : '0;
      result.path_len     = LEN_OUT_W'(path_f);
      result.query_len    = LEN_OUT_W'(query_f);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && step.last)) begin
      phase_r      <= PH_PROTO;
      byte_cnt_r   <= '0;
      cur_len_r    <= '0;
      proto_len_r  <= '0;
      host_len_r   <= '0;
      path_len_r   <= '0;
      query_len_r  <= '0;
      port_acc_r   <= '0;
      port_dig_r   <= '0;
      esc_left_r   <= '0;
      failed_r     <= 1'b0;
      port_taken_r <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      cur_len_r    <= cur_len_nxt;
      proto_len_r  <= proto_len_nxt;
      host_len_r   <= host_len_nxt;
      path_len_r   <= path_len_nxt;
      query_len_r  <= query_len_nxt;
      port_acc_r   <= port_acc_nxt;
      port_dig_r   <= port_dig_nxt;
      esc_left_r   <= esc_left_nxt;
      failed_r     <= failed_nxt;
      port_taken_r <= port_taken_nxt;
    end
  end

endmodule

// ===== design/url_component_parser.sv =====
// url component parser: takes a url of the form proto://host:port/path?query#rest
// one byte per item on the in_ channel, in_tlast set on the final byte
// one result item on the out_ channel for each url, nothing for earlier bytes
// result: ok flag, protocol/host/path/query lengths, port presence and value;
// on failure every field except ok is zero
// the last byte is held in the input register and its result in the result register;
// out_tvalid rises when the result register is loaded, which waits while the
// receiver has not yet taken an earlier result
// throughput: one byte per cycle, set by the phase update in the scanner, while no
// last byte waits for the result register; a new url may start on the cycle after
// the previous last byte; a waiting result does not block input bytes; only a last
// byte waits until the result register is free
// reset (rst_n low, synchronous) empties both registers and returns the
// scanner to the protocol phase; the scanner also returns there after each url
// a stalled receiver (out_tready low) holds the result and, once a further last
// byte is waiting, back-pressures in_tready
module url_component_parser #(
  parameter int unsigned MAX_LEN = urlcp_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch [7:0]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // ok [0], proto_len [11:1], host_len [22:12], port_present [23],
  // port_value [39:24], path_len [50:40], query_len [61:51], zero [63:62]
  output logic [63:0] out_tdata
);
  import urlcp_pkg::*;

  // input register
  logic        in_valid_r;
  step_t       in_step_r;

  // result register
  logic        out_valid_r;
  url_result_t out_res_r;

  url_result_t step_res;
  logic        out_free;
  logic        step_go;

  assign out_free  = !out_valid_r || out_tready;
  // a last byte needs the result register, any other byte proceeds at once
  assign step_go   = in_valid_r && (!in_step_r.last || out_free);
  assign in_tready = !in_valid_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_step_r.ch   <= in_tdata;
      in_step_r.last <= in_tlast;
    end
  end

  urlcp_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_go),
    .step    (in_step_r),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go && in_step_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && in_step_r.last) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.query_len, out_res_r.path_len,
                       out_res_r.port_value, out_res_r.port_present,
                       out_res_r.host_len, out_res_r.proto_len, out_res_r.ok};

endmodule
